// ----- rtl/vled_pkg.sv -----
// package: constants, types and register codes of the volume extremum detector
`timescale 1ns / 1ps

package vled_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_DEPTH  = 1024;
   localparam int VALUE_BITS = 16;

   // fixed widths of the beat fields and registers
   localparam int VOXEL_FIELD_BITS = 16;
   localparam int SIZE_X_BITS      = 9;
   localparam int SIZE_Y_BITS      = 9;
   localparam int SIZE_Z_BITS      = 11;
   localparam int MASK_BITS        = 26;
   localparam int POS_X_BITS       = 8;
   localparam int POS_Y_BITS       = 8;
   localparam int POS_Z_BITS       = 10;

   localparam int ENTRY_BITS = VALUE_BITS + 1;
   localparam int X_BITS     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int Y_BITS     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int Z_BITS     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int PLANE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int PA_BITS    = $clog2(PLANE_DEPTH);
   localparam int LAG_BITS   = $clog2(PLANE_DEPTH + MAX_WIDTH + 2);
   localparam int PROD_BITS  = SIZE_X_BITS + SIZE_Y_BITS + 1;

   localparam int PLANE_RAM_BITS = 2 * ENTRY_BITS;
   localparam int ROW_RAM_BITS   = 6 * ENTRY_BITS;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
   localparam int CREDIT_BITS   = $clog2(FIFO_DEPTH + 3);

   localparam int REG_COUNT     = 6;
   localparam int CSR_ADDR_BITS = $clog2(REG_COUNT * 4);
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int SETTLE_CYCLES = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_SIZE_X         = 3'd0,
      REG_SIZE_Y         = 3'd1,
      REG_SIZE_Z         = 3'd2,
      REG_STRICT_COMPARE = 3'd3,
      REG_FIND_MINIMUM   = 3'd4,
      REG_NEIGHBOR_MASK  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic                  emit;
      logic [X_BITS-1:0]     x;
      logic [Y_BITS-1:0]     y;
      logic [Z_BITS-1:0]     z;
      logic                  last;
   } pos_type;

   typedef struct packed {
      logic                  is_extremum;
      logic [POS_X_BITS-1:0] pos_x;
      logic [POS_Y_BITS-1:0] pos_y;
      logic [POS_Z_BITS-1:0] pos_z;
      logic                  last_voxel;
   } rsp_type;

endpackage

// ----- rtl/vled_if.sv -----
// interfaces: voxel request channel and extremum response channel
`timescale 1ns / 1ps

interface vled_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [vled_pkg::VOXEL_FIELD_BITS-1:0] voxel_value;
   logic                                 in_roi;
   logic                                 padding;

   modport source (output valid, output voxel_value, output in_roi, output padding,
                   input ready);
   modport sink   (input valid, input voxel_value, input in_roi, input padding,
                   output ready);
endinterface

interface vled_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            is_extremum;
   logic [vled_pkg::POS_X_BITS-1:0] pos_x;
   logic [vled_pkg::POS_Y_BITS-1:0] pos_y;
   logic [vled_pkg::POS_Z_BITS-1:0] pos_z;
   logic                            last_voxel;

   modport source (output valid, output is_extremum, output pos_x, output pos_y,
                   output pos_z, output last_voxel, input ready);
   modport sink   (input valid, input is_extremum, input pos_x, input pos_y,
                   input pos_z, input last_voxel, output ready);
endinterface

// ----- rtl/vled_ram.sv -----
// generic single-clock ram, one write and one read port, registered read-first data
`timescale 1ns / 1ps

module vled_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/volume_local_extremum_detect.sv -----
// top level: streaming 3x3x3 local maximum / minimum detector
//
//  channel   direction  kind            payload
//  req_chan  in         valid/ready     voxel_value, in_roi, padding
//  rsp_chan  out        valid/ready     is_extremum, pos_x, pos_y, pos_z, last_voxel
//  csr_*     in/out     apb, 32 bit     six registers at byte address 4*i
//
// one voxel beat per cycle while req_chan.ready is high; results pass stage one, two and the queue
// plane ram (two plane delays) and row ram (six row delays) are read at accept and
// written back the next cycle, same-cycle address hits are forwarded
// results lag the input by one plane, one row and one voxel; padding beats flush
// synchronous reset; no clearing pass, stale ram data only ever feeds out-of-volume taps
// req_chan.ready stays low while settling after reset or a register write; a four-deep result queue
// holds beats while rsp_chan stalls, and req_chan.ready drops when it could fill
`timescale 1ns / 1ps

module volume_local_extremum_detect (
   input  logic                                  clock,
   input  logic                                  reset,
   vled_req_if.sink                              req_chan,
   vled_rsp_if.source                            rsp_chan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [vled_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [vled_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [vled_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   localparam int E  = vled_pkg::ENTRY_BITS;
   localparam int VB = vled_pkg::VALUE_BITS;

   // configuration registers
   logic [vled_pkg::SIZE_X_BITS-1:0] size_x_ff, size_x_in;
   logic [vled_pkg::SIZE_Y_BITS-1:0] size_y_ff, size_y_in;
   logic [vled_pkg::SIZE_Z_BITS-1:0] size_z_ff, size_z_in;
   logic                             strict_ff, strict_in;
   logic                             find_min_ff, find_min_in;
   logic [vled_pkg::MASK_BITS-1:0]   nmask_ff, nmask_in;

   // derived sizes
   logic [vled_pkg::SIZE_X_BITS-1:0] w_eff;
   logic [vled_pkg::SIZE_Y_BITS-1:0] h_eff;
   logic [vled_pkg::SIZE_Z_BITS-1:0] d_eff;
   logic [vled_pkg::PROD_BITS-1:0]   wh_prod;
   logic [vled_pkg::X_BITS-1:0]      w_m1_ff;
   logic [vled_pkg::Y_BITS-1:0]      h_m1_ff;
   logic [vled_pkg::Z_BITS-1:0]      d_m1_ff;
   logic [vled_pkg::PA_BITS-1:0]     wh_m1_ff;
   logic [vled_pkg::LAG_BITS-1:0]    lag_ff;
   logic [1:0]                       settle_ff, settle_in;

   // input side positions
   logic [vled_pkg::PA_BITS-1:0]  pa_ff, pa_in;
   logic [vled_pkg::X_BITS-1:0]   ra_ff, ra_in;
   logic [vled_pkg::LAG_BITS-1:0] fill_ff, fill_in;
   logic [vled_pkg::X_BITS-1:0]   ox_ff, ox_in;
   logic [vled_pkg::Y_BITS-1:0]   oy_ff, oy_in;
   logic [vled_pkg::Z_BITS-1:0]   oz_ff, oz_in;

   // stage one
   logic                                    s1_valid_ff;
   logic [E-1:0]                            s1_cur_ff;
   logic [vled_pkg::PA_BITS-1:0]            s1_pa_ff;
   logic [vled_pkg::X_BITS-1:0]             s1_ra_ff;
   vled_pkg::pos_type                       s1_pos_ff;
   logic                                    s1_pfwd_ff;
   logic [vled_pkg::PLANE_RAM_BITS-1:0]     s1_pfwd_data_ff;
   logic                                    s1_rfwd_ff;
   logic [vled_pkg::ROW_RAM_BITS-1:0]       s1_rfwd_data_ff;

   // window, stage two and result queue
   logic [E-1:0]                            win_ff [3][3][3];
   logic                                    s2_valid_ff;
   vled_pkg::pos_type                       s2_pos_ff;
   vled_pkg::rsp_type                       fifo_ff [vled_pkg::FIFO_DEPTH];
   logic [vled_pkg::FIFO_PTR_BITS-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [vled_pkg::FIFO_CNT_BITS-1:0]      cnt_ff;

   logic                                    req_ready;
   logic                                    accept;
   logic                                    pop;
   logic                                    csr_write;
   logic [vled_pkg::CSR_IDX_BITS-1:0]       csr_idx;
   logic                                    cfg_hit;
   logic                                    primed;
   logic                                    last_q;
   logic [E-1:0]                            cur_entry;
   logic [vled_pkg::CREDIT_BITS-1:0]        credit_used;

   logic [vled_pkg::PLANE_RAM_BITS-1:0]     plane_rd_data, plane_old, plane_wr_data;
   logic [vled_pkg::ROW_RAM_BITS-1:0]       row_rd_data, row_old, row_wr_data;
   logic [E-1:0]                            stream [3];
   logic [E-1:0]                            rd1 [3];
   logic [E-1:0]                            rd2 [3];

   logic [E-1:0]                            centre;
   logic [vled_pkg::MASK_BITS-1:0]          rej;
   logic                                    lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
   vled_pkg::rsp_type                       rsp_new;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[vled_pkg::CSR_ADDR_BITS-1:2];
   assign cfg_hit    = csr_write && (csr_idx < vled_pkg::CSR_IDX_BITS'(vled_pkg::REG_COUNT));

   always_comb begin
      size_x_in   = size_x_ff;
      size_y_in   = size_y_ff;
      size_z_in   = size_z_ff;
      strict_in   = strict_ff;
      find_min_in = find_min_ff;
      nmask_in    = nmask_ff;
      if (csr_write) begin
         unique case (csr_idx)
            vled_pkg::REG_SIZE_X:         size_x_in   = csr_pwdata[vled_pkg::SIZE_X_BITS-1:0];
            vled_pkg::REG_SIZE_Y:         size_y_in   = csr_pwdata[vled_pkg::SIZE_Y_BITS-1:0];
            vled_pkg::REG_SIZE_Z:         size_z_in   = csr_pwdata[vled_pkg::SIZE_Z_BITS-1:0];
            vled_pkg::REG_STRICT_COMPARE: strict_in   = csr_pwdata[0];
            vled_pkg::REG_FIND_MINIMUM:   find_min_in = csr_pwdata[0];
            vled_pkg::REG_NEIGHBOR_MASK:  nmask_in    = csr_pwdata[vled_pkg::MASK_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         vled_pkg::REG_SIZE_X:         csr_prdata = vled_pkg::CSR_DATA_BITS'(size_x_ff);
         vled_pkg::REG_SIZE_Y:         csr_prdata = vled_pkg::CSR_DATA_BITS'(size_y_ff);
         vled_pkg::REG_SIZE_Z:         csr_prdata = vled_pkg::CSR_DATA_BITS'(size_z_ff);
         vled_pkg::REG_STRICT_COMPARE: csr_prdata = vled_pkg::CSR_DATA_BITS'(strict_ff);
         vled_pkg::REG_FIND_MINIMUM:   csr_prdata = vled_pkg::CSR_DATA_BITS'(find_min_ff);
         vled_pkg::REG_NEIGHBOR_MASK:  csr_prdata = vled_pkg::CSR_DATA_BITS'(nmask_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // zero means one, oversize saturates
   always_comb begin
      if (size_x_ff == '0) begin
         w_eff = vled_pkg::SIZE_X_BITS'(1);
      end else if (size_x_ff > vled_pkg::SIZE_X_BITS'(vled_pkg::MAX_WIDTH)) begin
         w_eff = vled_pkg::SIZE_X_BITS'(vled_pkg::MAX_WIDTH);
      end else begin
         w_eff = size_x_ff;
      end
      if (size_y_ff == '0) begin
         h_eff = vled_pkg::SIZE_Y_BITS'(1);
      end else if (size_y_ff > vled_pkg::SIZE_Y_BITS'(vled_pkg::MAX_HEIGHT)) begin
         h_eff = vled_pkg::SIZE_Y_BITS'(vled_pkg::MAX_HEIGHT);
      end else begin
         h_eff = size_y_ff;
      end
      if (size_z_ff == '0) begin
         d_eff = vled_pkg::SIZE_Z_BITS'(1);
      end else if (size_z_ff > vled_pkg::SIZE_Z_BITS'(vled_pkg::MAX_DEPTH)) begin
         d_eff = vled_pkg::SIZE_Z_BITS'(vled_pkg::MAX_DEPTH);
      end else begin
         d_eff = size_z_ff;
      end
   end

   assign wh_prod = vled_pkg::PROD_BITS'(w_eff) * vled_pkg::PROD_BITS'(h_eff);

   always_ff @(posedge clock) begin
      w_m1_ff  <= vled_pkg::X_BITS'(w_eff - 1'b1);
      h_m1_ff  <= vled_pkg::Y_BITS'(h_eff - 1'b1);
      d_m1_ff  <= vled_pkg::Z_BITS'(d_eff - 1'b1);
      wh_m1_ff <= vled_pkg::PA_BITS'(wh_prod - 1'b1);
      lag_ff   <= vled_pkg::LAG_BITS'(wh_prod + vled_pkg::PROD_BITS'(w_eff) + 1'b1);
   end

   always_comb begin
      if (csr_write) begin
         settle_in = 2'(vled_pkg::SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end else begin
         settle_in = settle_ff;
      end
   end

   // ---------------- input side ----------------
   assign credit_used = vled_pkg::CREDIT_BITS'(cnt_ff) + vled_pkg::CREDIT_BITS'(s1_valid_ff)
                      + vled_pkg::CREDIT_BITS'(s2_valid_ff);
   assign req_ready   = (settle_ff == '0)
                      && (credit_used < vled_pkg::CREDIT_BITS'(vled_pkg::FIFO_DEPTH));
   assign req_chan.ready = req_ready;
   assign accept = req_chan.valid && req_ready;

   assign primed = (fill_ff == lag_ff);
   assign last_q = (ox_ff == w_m1_ff) && (oy_ff == h_m1_ff) && (oz_ff == d_m1_ff);
   assign cur_entry = req_chan.padding ? '0
                    : {req_chan.in_roi, req_chan.voxel_value[VB-1:0]};

   always_comb begin
      pa_in   = pa_ff;
      ra_in   = ra_ff;
      fill_in = fill_ff;
      ox_in   = ox_ff;
      oy_in   = oy_ff;
      oz_in   = oz_ff;
      priority if (cfg_hit) begin
         pa_in   = '0;
         ra_in   = '0;
         fill_in = '0;
         ox_in   = '0;
         oy_in   = '0;
         oz_in   = '0;
      end else if (accept) begin
         pa_in = (pa_ff == wh_m1_ff) ? '0 : pa_ff + 1'b1;
         ra_in = (ra_ff == w_m1_ff) ? '0 : ra_ff + 1'b1;
         if (!primed) begin
            fill_in = fill_ff + 1'b1;
         end else if (last_q) begin
            // end of volume: next beat opens a new one
            pa_in   = '0;
            ra_in   = '0;
            fill_in = '0;
            ox_in   = '0;
            oy_in   = '0;
            oz_in   = '0;
         end else if (ox_ff != w_m1_ff) begin
            ox_in = ox_ff + 1'b1;
         end else begin
            ox_in = '0;
            if (oy_ff != h_m1_ff) begin
               oy_in = oy_ff + 1'b1;
            end else begin
               oy_in = '0;
               oz_in = oz_ff + 1'b1;
            end
         end
      end
   end

   // ---------------- memories ----------------
   vled_ram #(
      .WIDTH (vled_pkg::PLANE_RAM_BITS),
      .DEPTH (vled_pkg::PLANE_DEPTH)
   ) u_plane_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_pa_ff),
      .wr_data (plane_wr_data),
      .rd_addr (pa_ff),
      .rd_data (plane_rd_data)
   );

   vled_ram #(
      .WIDTH (vled_pkg::ROW_RAM_BITS),
      .DEPTH (vled_pkg::MAX_WIDTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ra_ff),
      .wr_data (row_wr_data),
      .rd_addr (ra_ff),
      .rd_data (row_rd_data)
   );

   // ---------------- stage one: delay lines and window shift ----------------
   assign plane_old     = s1_pfwd_ff ? s1_pfwd_data_ff : plane_rd_data;
   assign plane_wr_data = {plane_old[E-1:0], s1_cur_ff};
   assign row_old       = s1_rfwd_ff ? s1_rfwd_data_ff : row_rd_data;

   always_comb begin
      stream[0] = s1_cur_ff;
      stream[1] = plane_old[E-1:0];
      stream[2] = plane_old[2*E-1:E];
      for (int a = 0; a < 3; a++) begin
         rd1[a] = row_old[a*2*E +: E];
         rd2[a] = row_old[a*2*E+E +: E];
         row_wr_data[a*2*E +: 2*E] = {rd1[a], stream[a]};
      end
   end

   // ---------------- stage two: 26 neighbour compares ----------------
   assign centre = win_ff[1][1][1];
   assign lo_x = (s2_pos_ff.x != '0);
   assign hi_x = (s2_pos_ff.x != w_m1_ff);
   assign lo_y = (s2_pos_ff.y != '0);
   assign hi_y = (s2_pos_ff.y != h_m1_ff);
   assign lo_z = (s2_pos_ff.z != '0);
   assign hi_z = (s2_pos_ff.z != d_m1_ff);

   for (genvar k = 0; k < 27; k++) begin : g_nb
      if (k != 13) begin : g_use
         localparam int DZ  = k / 9 - 1;
         localparam int DY  = (k / 3) % 3 - 1;
         localparam int DX  = k % 3 - 1;
         localparam int BIT = (k < 13) ? k : k - 1;
         logic [E-1:0]  nb;
         logic          inb_x, inb_y, inb_z, cmp;
         assign nb    = win_ff[1-DZ][1-DY][1-DX];
         assign inb_x = (DX < 0) ? lo_x : ((DX > 0) ? hi_x : 1'b1);
         assign inb_y = (DY < 0) ? lo_y : ((DY > 0) ? hi_y : 1'b1);
         assign inb_z = (DZ < 0) ? lo_z : ((DZ > 0) ? hi_z : 1'b1);
         assign cmp   = find_min_ff
                      ? (strict_ff ? (nb[VB-1:0] <= centre[VB-1:0])
                                   : (nb[VB-1:0] <  centre[VB-1:0]))
                      : (strict_ff ? (nb[VB-1:0] >= centre[VB-1:0])
                                   : (nb[VB-1:0] >  centre[VB-1:0]));
         assign rej[BIT] = nmask_ff[BIT] && inb_x && inb_y && inb_z && nb[E-1] && cmp;
      end
   end

   always_comb begin
      rsp_new.is_extremum = centre[E-1] && (rej == '0);
      rsp_new.pos_x       = vled_pkg::POS_X_BITS'(s2_pos_ff.x);
      rsp_new.pos_y       = vled_pkg::POS_Y_BITS'(s2_pos_ff.y);
      rsp_new.pos_z       = vled_pkg::POS_Z_BITS'(s2_pos_ff.z);
      rsp_new.last_voxel  = s2_pos_ff.last;
   end

   // ---------------- result queue ----------------
   assign pop = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid       = (cnt_ff != '0);
   assign rsp_chan.is_extremum = fifo_ff[rd_ptr_ff].is_extremum;
   assign rsp_chan.pos_x       = fifo_ff[rd_ptr_ff].pos_x;
   assign rsp_chan.pos_y       = fifo_ff[rd_ptr_ff].pos_y;
   assign rsp_chan.pos_z       = fifo_ff[rd_ptr_ff].pos_z;
   assign rsp_chan.last_voxel  = fifo_ff[rd_ptr_ff].last_voxel;

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= rsp_new;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff   <= vled_pkg::SIZE_X_BITS'(256);
         size_y_ff   <= vled_pkg::SIZE_Y_BITS'(256);
         size_z_ff   <= vled_pkg::SIZE_Z_BITS'(1);
         strict_ff   <= 1'b0;
         find_min_ff <= 1'b0;
         nmask_ff    <= '1;
         settle_ff   <= 2'(vled_pkg::SETTLE_CYCLES);
         pa_ff       <= '0;
         ra_ff       <= '0;
         fill_ff     <= '0;
         ox_ff       <= '0;
         oy_ff       <= '0;
         oz_ff       <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         cnt_ff      <= '0;
      end else begin
         size_x_ff   <= size_x_in;
         size_y_ff   <= size_y_in;
         size_z_ff   <= size_z_in;
         strict_ff   <= strict_in;
         find_min_ff <= find_min_in;
         nmask_ff    <= nmask_in;
         settle_ff   <= settle_in;
         pa_ff       <= pa_in;
         ra_ff       <= ra_in;
         fill_ff     <= fill_in;
         ox_ff       <= ox_in;
         oy_ff       <= oy_in;
         oz_ff       <= oz_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff && s1_pos_ff.emit;
         if (s2_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + vled_pkg::FIFO_CNT_BITS'(s2_valid_ff)
                          - vled_pkg::FIFO_CNT_BITS'(pop);
      end
   end

   // stage one payload, with forwarding when the ram is written at the address read now
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff       <= cur_entry;
         s1_pa_ff        <= pa_ff;
         s1_ra_ff        <= ra_ff;
         s1_pos_ff.emit  <= primed;
         s1_pos_ff.x     <= ox_ff;
         s1_pos_ff.y     <= oy_ff;
         s1_pos_ff.z     <= oz_ff;
         s1_pos_ff.last  <= last_q;
         s1_pfwd_ff      <= s1_valid_ff && (s1_pa_ff == pa_ff);
         s1_pfwd_data_ff <= plane_wr_data;
         s1_rfwd_ff      <= s1_valid_ff && (s1_ra_ff == ra_ff);
         s1_rfwd_data_ff <= row_wr_data;
      end
      if (s1_valid_ff) begin
         s2_pos_ff <= s1_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
               for (int c = 0; c < 3; c++) begin
                  win_ff[a][b][c] <= '0;
               end
            end
         end
      end else if (s1_valid_ff) begin
         for (int a = 0; a < 3; a++) begin
            win_ff[a][0][2] <= win_ff[a][0][1];
            win_ff[a][0][1] <= win_ff[a][0][0];
            win_ff[a][0][0] <= stream[a];
            win_ff[a][1][2] <= win_ff[a][1][1];
            win_ff[a][1][1] <= win_ff[a][1][0];
            win_ff[a][1][0] <= rd1[a];
            win_ff[a][2][2] <= win_ff[a][2][1];
            win_ff[a][2][1] <= win_ff[a][2][0];
            win_ff[a][2][0] <= rd2[a];
         end
      end
   end

endmodule
